// ===== src/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear-probe hash table
// Table geometry, operation and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  // Table geometry
  localparam int SLOTS       = 256;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int HALF_SLOTS  = SLOTS / 2;
  localparam int KEY_W       = 32;
  localparam int VALUE_WIDTH = 32;

  // Mixer constants
  localparam logic [31:0] HASH_MUL1 = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL2 = 32'h846ca68b;

  // Operation codes
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_EXISTS = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  // Slot states
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture input transaction, first xor-shift
    logic mul1;    // first multiply
    logic mul2;    // second multiply
    logic home;    // set probe pointer to home slot
    logic fetch;   // first slot read
    logic probe;   // evaluate slot, read the next
    logic commit;  // update table, load result register
  } lpht_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic             probe_done;
    logic             out_valid;
    logic [CNT_W-1:0] count;
  } lpht_stat_t;

endpackage

`default_nettype wire

// ===== src/lpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpht_ctrl: sequencer for one hash table operation
// Steps the hash, the probe loop and the commit, one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lpht_pkg::lpht_stat_t stat,
  output lpht_pkg::lpht_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_HOME, S_FETCH, S_PROBE, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_HOME;
      S_HOME:  state_next = S_FETCH;
      S_FETCH: state_next = S_PROBE;
      S_PROBE: if (stat.probe_done) state_next = S_DONE;
      S_DONE:  if (!stat.out_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.mul1   = (state == S_MUL1);
    cmd.mul2   = (state == S_MUL2);
    cmd.home   = (state == S_HOME);
    cmd.fetch  = (state == S_FETCH);
    cmd.probe  = (state == S_PROBE);
    cmd.commit = (state == S_DONE) && !stat.out_valid;
  end

endmodule

`default_nettype wire

// ===== src/lpht_dpath.sv =====
// ----------------------------------------------------------------------------
// lpht_dpath: hash, slot memories, probe evaluation and result register
// Holds the table and does the work each controller command asks for.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lpht_pkg::lpht_cmd_t             cmd,
  output lpht_pkg::lpht_stat_t                 stat,
  input  wire logic [1:0]                      in_mode,
  input  wire logic [lpht_pkg::KEY_W-1:0]      in_key,
  input  wire logic [lpht_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_status,
  output logic                                 out_found,
  output logic [lpht_pkg::VALUE_WIDTH-1:0]     out_value
);

  localparam int IW = lpht_pkg::IDX_W;
  localparam int CW = lpht_pkg::CNT_W;
  localparam int VW = lpht_pkg::VALUE_WIDTH;

  // Operation registers
  logic [1:0]                   mode_r;
  logic [lpht_pkg::KEY_W-1:0]   key_r;
  logic [VW-1:0]                val_r;
  logic [31:0]                  hx;
  logic [31:0]                  hm1;
  logic [31:0]                  hm2;
  logic [31:0]                  hy;
  logic [31:0]                  prod1;
  logic [31:0]                  prod2;
  logic [31:0]                  hfin;

  // Slot storage
  logic [lpht_pkg::KEY_W-1:0]   keys_mem [lpht_pkg::SLOTS];
  logic [VW-1:0]                vals_mem [lpht_pkg::SLOTS];
  logic [1:0]                   stat_mem [lpht_pkg::SLOTS];
  logic [lpht_pkg::SLOTS-1:0]   slot_vld;
  logic [lpht_pkg::KEY_W-1:0]   key_q;
  logic [VW-1:0]                val_q;
  logic [1:0]                   stat_q;
  logic                         vld_q;

  // Probe state
  logic [IW-1:0] ptr;
  logic [IW-1:0] cur;
  logic [IW-1:0] n;
  logic [IW-1:0] free_idx;
  logic          free_seen;
  logic [IW-1:0] hit_idx;
  logic [VW-1:0] hit_val;
  logic          found;
  logic [CW-1:0] count;

  logic [1:0]    slot_st;
  logic          match;
  logic          done;

  // Write port
  logic          we;
  logic          kv_we;
  logic [IW-1:0] wr_idx;
  logic [1:0]    wr_st;
  logic [1:0]    res_status;
  logic [VW-1:0] res_value;
  logic [CW-1:0] count_next;

  // Mixer: xor-shift, multiply, xor-shift, multiply, xor-shift (products mod 2^32)
  assign prod1 = hx * lpht_pkg::HASH_MUL1;
  assign hy    = hm1 ^ (hm1 >> 15);
  assign prod2 = hy * lpht_pkg::HASH_MUL2;
  assign hfin  = hm2 ^ (hm2 >> 16);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      val_r  <= in_value;
      hx     <= in_key ^ (in_key >> 16);
    end
    if (cmd.mul1) hm1 <= prod1;
    if (cmd.mul2) hm2 <= prod2;
  end

  // Registered slot read at the probe pointer
  always_ff @(posedge clk) begin
    key_q  <= keys_mem[ptr];
    val_q  <= vals_mem[ptr];
    stat_q <= stat_mem[ptr];
    vld_q  <= slot_vld[ptr];
    cur    <= ptr;
  end

  // Slot evaluation
  assign slot_st = vld_q ? stat_q : lpht_pkg::SLOT_EMPTY;
  assign match   = (slot_st == lpht_pkg::SLOT_USED) && (key_q == key_r);
  assign done    = match || (slot_st == lpht_pkg::SLOT_EMPTY) || (n == {IW{1'b1}});

  // Probe bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.home) begin
      ptr       <= hfin[IW-1:0];
      n         <= '0;
      free_seen <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.fetch) begin
      ptr <= ptr + 1'b1;
    end else if (cmd.probe) begin
      ptr <= ptr + 1'b1;
      n   <= n + 1'b1;
      if (slot_st != lpht_pkg::SLOT_USED && !free_seen) begin
        free_seen <= 1'b1;
        free_idx  <= cur;
      end
      if (match) begin
        found   <= 1'b1;
        hit_idx <= cur;
        hit_val <= val_q;
      end
    end
  end

  // Commit decision
  always_comb begin
    we         = 1'b0;
    kv_we      = 1'b0;
    wr_idx     = hit_idx;
    wr_st      = lpht_pkg::SLOT_TOMB;
    res_value  = '0;
    res_status = lpht_pkg::STAT_OK;
    count_next = count;
    case (mode_r)
      lpht_pkg::MODE_INSERT: begin
        if (found) begin
          res_status = lpht_pkg::STAT_EXISTS;
        end else if (count >= CW'(lpht_pkg::HALF_SLOTS) || !free_seen) begin
          res_status = lpht_pkg::STAT_FULL;
        end else begin
          we         = 1'b1;
          kv_we      = 1'b1;
          wr_idx     = free_idx;
          wr_st      = lpht_pkg::SLOT_USED;
          count_next = count + 1'b1;
        end
      end
      lpht_pkg::MODE_REMOVE: begin
        if (found) begin
          we         = 1'b1;
          res_value  = hit_val;
          count_next = (count != '0) ? count - 1'b1 : count;
        end else begin
          res_status = lpht_pkg::STAT_ABSENT;
        end
      end
      default: begin
        if (found) res_value = hit_val;
        else res_status = lpht_pkg::STAT_ABSENT;
      end
    endcase
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (cmd.commit && kv_we) begin
      keys_mem[wr_idx] <= key_r;
      vals_mem[wr_idx] <= val_r;
    end
    if (cmd.commit && we) stat_mem[wr_idx] <= wr_st;
  end

  // Slot valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      count    <= '0;
    end else if (cmd.commit) begin
      if (we) slot_vld[wr_idx] <= 1'b1;
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_found  <= found;
      out_value  <= res_value;
    end
  end

  assign stat.probe_done = done;
  assign stat.out_valid  = out_valid;
  assign stat.count      = count;

endmodule

`default_nettype wire

// ===== src/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table: 256-slot open-addressing table with 32-bit keys
// Lookup, insert and remove on a stream interface, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_*: s_tuser is the operation (0 lookup, 1 insert,
//   2 remove), s_tdata carries key and value. Each request returns exactly
//   one result on m_*: m_tuser holds status and found, m_tdata the value.
//   Keys are hashed with a two-multiply mixer; the low 8 bits give the home
//   slot, and slots are read one per cycle until a match, an empty slot or
//   a sweep of all 256 slots. The hash is formed in the load, multiply and
//   home steps, then the first slot is fetched, the probe loop runs and the
//   result is committed. One request is in flight at a time: a new request
//   is accepted only after the previous one has committed its result.
//   Inserts beyond 128 entries report full; removals leave tombstones.
//   Reset empties the table at once through per-slot valid bits.
//   A finished result waits in the output register while m_tready is low;
//   the next request is still accepted and processed up to its commit.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // key[31:0], value[63:32]
  input  wire logic [1:0]  s_tuser,   // mode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // result_value[31:0]
  output logic [2:0]       m_tuser    // status[1:0], found[2]
);

  lpht_pkg::lpht_cmd_t  cmd;
  lpht_pkg::lpht_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpht_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (s_tuser),
    .in_key     (s_tdata[31:0]),
    .in_value   (s_tdata[63:32]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser[1:0]),
    .out_found  (m_tuser[2]),
    .out_value  (m_tdata)
  );

  // Occupancy never exceeds half the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= lpht_pkg::CNT_W'(lpht_pkg::HALF_SLOTS))
    else $error("entry count above half capacity");

  // One request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  // A found key reports ok or duplicate only
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |->
      (m_tuser[1:0] == lpht_pkg::STAT_OK || m_tuser[1:0] == lpht_pkg::STAT_EXISTS))
    else $error("found result with miss or full status");

  // Commit only into a free result register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !m_tvalid)
    else $error("result overwritten before delivery");

endmodule

`default_nettype wire
